// File: hdl/tcprw_pkg.sv
package tcprw_pkg;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_HDR  = 2'd1,
    OP_DATA = 2'd2,
    OP_READ = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] seq;
    logic [15:0] length;
    logic [31:0] seg_end;
    logic        zero_len;
    logic [7:0]  data_byte;
    logic        last;
  } q_entry_t;

  // Status from the back that the front needs for its handshake.
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

// File: hdl/tcprw_front.sv
module tcprw_front (
  input  logic                   start,
  input  logic [1:0]             in_opcode,
  input  logic [31:0]            in_seq_number,
  input  logic [15:0]            in_seg_length,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_last_of_segment,
  input  logic                   q_full,
  input  tcprw_pkg::back_stat_t  stat,
  output logic                   busy,
  output logic                   push,
  output tcprw_pkg::q_entry_t    entry
);
  import tcprw_pkg::*;

  assign busy = q_full | stat.clearing;
  assign push = start & ~busy;

  // The segment end and the empty-segment flag are worked out here so the
  // back only compares.
  always_comb begin
    entry.opcode    = opcode_t'(in_opcode);
    entry.seq       = in_seq_number;
    entry.length    = in_seg_length;
    entry.seg_end   = in_seq_number + {16'd0, in_seg_length} - 32'd1;
    entry.zero_len  = (in_seg_length == 16'd0);
    entry.data_byte = in_data_byte;
    entry.last      = in_last_of_segment;
  end

endmodule

// File: hdl/tcprw_queue.sv
module tcprw_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tcprw_pkg::q_entry_t  push_entry,
  input  logic                 pop,
  output tcprw_pkg::q_entry_t  head,
  output logic                 empty,
  output logic                 full
);
  import tcprw_pkg::*;

  q_entry_t   store_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + 1'b1;
    rd_ptr_nxt = rd_ptr_r + 1'b1;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop) rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/tcprw_back.sv
module tcprw_back #(
  parameter int WINDOW_BYTES = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcprw_pkg::q_entry_t    head,
  input  logic                   q_empty,
  output logic                   pop,
  output tcprw_pkg::back_stat_t  stat,
  output logic                   out_valid,
  output logic [1:0]             out_result_kind,
  output logic [31:0]            out_ack_seq,
  output logic [7:0]             out_read_byte
);
  import tcprw_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DATA_CHK, S_WALK_RD, S_WALK_CHK, S_READ_OUT
  } state_t;

  // Received map and ring store, both with a registered read port.
  logic          map_mem [WINDOW_BYTES];
  logic [7:0]    ring_mem [WINDOW_BYTES];
  logic          map_rd_r;
  logic [7:0]    ring_rd_r;
  logic          map_we, map_wd;
  logic [AW-1:0] map_wa, map_ra;
  logic          ring_we;
  logic [AW-1:0] ring_wa, ring_ra;

  state_t        state_r, state_nxt;
  logic [31:0]   ne_r, ne_nxt;
  logic [31:0]   rp_r, rp_nxt;
  logic [31:0]   sstart_r, sstart_nxt;
  logic [31:0]   send_r, send_nxt;
  logic [15:0]   slen_r, slen_nxt;
  logic [15:0]   bp_r, bp_nxt;
  logic          acc_r, acc_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [7:0]    dbyte_r, dbyte_nxt;
  logic          dok_r, dok_nxt;
  logic          dlast_r, dlast_nxt;
  logic [31:0]   sp_r, sp_nxt;
  logic          ov_r, ov_nxt;
  kind_t         kind_r, kind_nxt;
  logic [31:0]   ack_r, ack_nxt;
  logic [7:0]    rbyte_r, rbyte_nxt;

  logic [31:0]   top;
  logic [31:0]   dseq;

  assign top  = rp_r + 32'(WINDOW_BYTES) - 32'd1;
  assign dseq = sstart_r + {16'd0, bp_r};

  assign stat.clearing   = (state_r == S_CLEAR);
  assign out_valid       = ov_r;
  assign out_result_kind = kind_r;
  assign out_ack_seq     = ack_r;
  assign out_read_byte   = rbyte_r;

  always_comb begin
    state_nxt  = state_r;
    ne_nxt     = ne_r;
    rp_nxt     = rp_r;
    sstart_nxt = sstart_r;
    send_nxt   = send_r;
    slen_nxt   = slen_r;
    bp_nxt     = bp_r;
    acc_nxt    = acc_r;
    clr_nxt    = clr_r;
    slot_nxt   = slot_r;
    dbyte_nxt  = dbyte_r;
    dok_nxt    = dok_r;
    dlast_nxt  = dlast_r;
    sp_nxt     = sp_r;
    ov_nxt     = 1'b0;
    kind_nxt   = kind_r;
    ack_nxt    = ack_r;
    rbyte_nxt  = rbyte_r;
    pop        = 1'b0;
    map_we     = 1'b0;
    map_wd     = 1'b0;
    map_wa     = clr_r;
    map_ra     = dseq[AW-1:0];
    ring_we    = 1'b0;
    ring_wa    = slot_r;
    ring_ra    = rp_r[AW-1:0];

    case (state_r)
      S_CLEAR: begin
        map_we  = 1'b1;
        map_wd  = 1'b0;
        map_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(WINDOW_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (head.opcode)
            OP_INIT: begin
              ne_nxt    = head.seq + 32'd1;
              rp_nxt    = head.seq + 32'd1;
              acc_nxt   = 1'b0;
              bp_nxt    = 16'd0;
              clr_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            OP_HDR: begin
              acc_nxt = 1'b0;
              bp_nxt  = 16'd0;
              if (head.seq > top) begin
                acc_nxt = 1'b0;
              end else if (head.seg_end < ne_r) begin
                ov_nxt    = 1'b1;
                kind_nxt  = KIND_ACK;
                ack_nxt   = ne_r;
                rbyte_nxt = 8'd0;
              end else if (!head.zero_len) begin
                sstart_nxt = head.seq;
                send_nxt   = head.seg_end;
                slen_nxt   = head.length;
                acc_nxt    = 1'b1;
              end
            end
            OP_DATA: begin
              if (acc_r) begin
                map_ra    = dseq[AW-1:0];
                slot_nxt  = dseq[AW-1:0];
                dbyte_nxt = head.data_byte;
                dok_nxt   = (bp_r < slen_r) && (dseq >= ne_r) &&
                            (dseq <= send_r) && (dseq <= top);
                dlast_nxt = head.last;
                if (head.last) begin
                  acc_nxt = 1'b0;
                  bp_nxt  = 16'd0;
                end else if (bp_r != 16'hFFFF) begin
                  bp_nxt = bp_r + 16'd1;
                end
                state_nxt = S_DATA_CHK;
              end
            end
            OP_READ: begin
              if (rp_r < ne_r) begin
                ring_ra   = rp_r[AW-1:0];
                slot_nxt  = rp_r[AW-1:0];
                state_nxt = S_READ_OUT;
              end else begin
                ov_nxt    = 1'b1;
                kind_nxt  = KIND_EMPTY;
                ack_nxt   = 32'd0;
                rbyte_nxt = 8'd0;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_DATA_CHK: begin
        if (dok_r && !map_rd_r) begin
          map_we  = 1'b1;
          map_wd  = 1'b1;
          map_wa  = slot_r;
          ring_we = 1'b1;
          ring_wa = slot_r;
        end
        if (dlast_r) begin
          sp_nxt    = ne_r;
          state_nxt = S_WALK_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK_RD: begin
        if ((ne_r - rp_r) < 32'(WINDOW_BYTES)) begin
          map_ra    = ne_r[AW-1:0];
          state_nxt = S_WALK_CHK;
        end else begin
          state_nxt = S_IDLE;
          if (ne_r != sp_r) begin
            ov_nxt    = 1'b1;
            kind_nxt  = KIND_ACK;
            ack_nxt   = ne_r;
            rbyte_nxt = 8'd0;
          end
        end
      end
      S_WALK_CHK: begin
        if (map_rd_r) begin
          ne_nxt    = ne_r + 32'd1;
          state_nxt = S_WALK_RD;
        end else begin
          state_nxt = S_IDLE;
          if (ne_r != sp_r) begin
            ov_nxt    = 1'b1;
            kind_nxt  = KIND_ACK;
            ack_nxt   = ne_r;
            rbyte_nxt = 8'd0;
          end
        end
      end
      S_READ_OUT: begin
        map_we    = 1'b1;
        map_wd    = 1'b0;
        map_wa    = slot_r;
        rp_nxt    = rp_r + 32'd1;
        ov_nxt    = 1'b1;
        kind_nxt  = KIND_BYTE;
        ack_nxt   = 32'd0;
        rbyte_nxt = ring_rd_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd_r <= map_mem[map_ra];
    if (ring_we) ring_mem[ring_wa] <= dbyte_r;
    ring_rd_r <= ring_mem[ring_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      ne_r     <= 32'd0;
      rp_r     <= 32'd0;
      sstart_r <= 32'd0;
      send_r   <= 32'd0;
      slen_r   <= 16'd0;
      bp_r     <= 16'd0;
      acc_r    <= 1'b0;
      clr_r    <= '0;
      ov_r     <= 1'b0;
      kind_r   <= KIND_ACK;
      ack_r    <= 32'd0;
      rbyte_r  <= 8'd0;
    end else begin
      state_r  <= state_nxt;
      ne_r     <= ne_nxt;
      rp_r     <= rp_nxt;
      sstart_r <= sstart_nxt;
      send_r   <= send_nxt;
      slen_r   <= slen_nxt;
      bp_r     <= bp_nxt;
      acc_r    <= acc_nxt;
      clr_r    <= clr_nxt;
      ov_r     <= ov_nxt;
      kind_r   <= kind_nxt;
      ack_r    <= ack_nxt;
      rbyte_r  <= rbyte_nxt;
    end
    slot_r  <= slot_nxt;
    dbyte_r <= dbyte_nxt;
    dok_r   <= dok_nxt;
    dlast_r <= dlast_nxt;
    sp_r    <= sp_nxt;
  end

endmodule

// File: hdl/tcp_receive_reassembly_window.sv
// Channel   Ports                                     Transfer when
// input     start, busy, in_opcode, in_seq_number,   start high and busy low
//           in_seg_length, in_data_byte, in_last_of_segment
// result    out_valid, out_result_kind,              out_valid high (one cycle,
//           out_ack_seq, out_read_byte                the receiver cannot stall)
//
// An empty read or a header for acked data yields a registered result; a read
// that delivers a byte first reads the ring store, and a data byte is checked
// against the map before it is written. On a segment's last byte the ack walk
// reads the map slot by slot up to the first gap or the top of the window.
// Reset, and every init item, start a clearing pass over the received map; busy
// stays high through the pass that follows reset. A two-entry queue sits between
// front and back, so busy rises only when it is full or the map is clearing.
// WINDOW_BYTES must be a power of two; the block itself does not check it.
module tcp_receive_reassembly_window #(
  parameter int WINDOW_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_seq_number,
  input  logic [15:0] in_seg_length,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_of_segment,
  output logic        out_valid,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_ack_seq,
  output logic [7:0]  out_read_byte
);
  import tcprw_pkg::*;

  q_entry_t   push_entry;
  q_entry_t   head;
  logic       push, pop, q_empty, q_full;
  back_stat_t stat;

  // The front decodes each transfer and computes the segment end.
  tcprw_front u_front (
    .start              (start),
    .in_opcode          (in_opcode),
    .in_seq_number      (in_seq_number),
    .in_seg_length      (in_seg_length),
    .in_data_byte       (in_data_byte),
    .in_last_of_segment (in_last_of_segment),
    .q_full             (q_full),
    .stat               (stat),
    .busy               (busy),
    .push               (push),
    .entry              (push_entry)
  );

  tcprw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // The back owns the window pointers, the received map and the ring store.
  tcprw_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_empty),
    .pop             (pop),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_ack_seq     (out_ack_seq),
    .out_read_byte   (out_read_byte)
  );

  // The map clearing pass must hold the input off right after reset.
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");

  // A result kind outside the three defined kinds is never sent.
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_kind == KIND_ACK || out_result_kind == KIND_BYTE ||
                   out_result_kind == KIND_EMPTY))
    else $error("illegal result kind");

  // An ack carries no byte; this assertion checks that a byte or empty result carries no ack.
  a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind != KIND_ACK) |-> (out_ack_seq == 32'd0))
    else $error("ack field not zero on a read result");

  // Nothing is pushed while the queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("queue overflow");

endmodule
